// ===== src/ctp_pkg.sv =====
package ctp_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned ColorW = 32;
  localparam int unsigned SlotW  = 3;

  localparam logic [SlotW-1:0] SlotRed   = 3'd0;
  localparam logic [SlotW-1:0] SlotGreen = 3'd1;
  localparam logic [SlotW-1:0] SlotBlue  = 3'd2;
  localparam logic [SlotW-1:0] SlotAlpha = 3'd3;
  localparam logic [SlotW-1:0] SlotNone  = 3'd4;
  localparam logic [SlotW-1:0] SlotWord  = 3'd7;

  localparam logic [ColorW-1:0] MaskRed   = 32'hFF00FFFF;
  localparam logic [ColorW-1:0] MaskGreen = 32'hFFFF00FF;
  localparam logic [ColorW-1:0] MaskBlue  = 32'hFFFFFF00;
  localparam logic [ColorW-1:0] MaskAlpha = 32'h00FFFFFF;

  localparam logic [CharW-1:0] ChSpace = 8'h20;
  localparam logic [CharW-1:0] ChTab   = 8'h09;
  localparam logic [CharW-1:0] ChHash  = 8'h23;
  localparam logic [CharW-1:0] ChLowX  = 8'h78;
  localparam logic [CharW-1:0] ChUpX   = 8'h58;

  // Writes the accumulator into the selected channel (SlotWord: whole
  // word; SlotNone: none); high bits spill into the channels above it.
  function automatic logic [ColorW-1:0] write_channel(
    input logic [ColorW-1:0] color,
    input logic [ColorW-1:0] acc,
    input logic [SlotW-1:0]  slot
  );
    logic [ColorW-1:0] res;
    res = color;
    unique case (slot)
      SlotWord:  res = acc;
      SlotRed:   res = (color & MaskRed) | (acc << 16);
      SlotGreen: res = (color & MaskGreen) | (acc << 8);
      SlotBlue:  res = (color & MaskBlue) | acc;
      SlotAlpha: res = (color & MaskAlpha) | (acc << 24);
      default:   res = color;
    endcase
    return res;
  endfunction

endpackage

// ===== src/color_text_parser_unit.sv =====
// Color text parser.
// The slave channel carries one text byte per word in s_axis_tdata_i; a word
// with s_axis_tlast_i high ends the string and its byte is not used. Each
// ordinary byte updates the parse state in the cycle it is accepted and
// produces no output. The end word writes a nonzero pending number into its
// channel and, in the cycle after acceptance, presents the packed color word
// (alpha 31-24, red 23-16, green 15-8, blue 7-0) on the master channel.
// Throughput is one word per cycle while no end word is held off; the
// accumulator update is a shift-add times ten or a shift times sixteen.
// The result sits in an output register. While it waits for the receiver,
// ordinary bytes are still accepted; only a further end word is held off
// until the waiting color word has been taken.
// Reset clears the color word to zero, empties the output register and
// puts the parser at the start of a string (decimal, red, skipping blanks).
// The color word persists from one string to the next.
module color_text_parser_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [ctp_pkg::CharW-1:0]    s_axis_tdata_i,  // [7:0] character
  input  logic                         s_axis_tlast_i,  // end_of_string
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [ctp_pkg::ColorW-1:0]   m_axis_tdata_o   // [31:0] color_word
);

  logic [ctp_pkg::ColorW-1:0] color_q, color_d;
  logic [ctp_pkg::ColorW-1:0] acc_q, acc_d;
  logic                       hex_q, hex_d;
  logic [ctp_pkg::SlotW-1:0]  slot_q, slot_d;
  logic                       lead_q, lead_d;
  logic                       out_valid_q, out_valid_d;
  logic [ctp_pkg::ColorW-1:0] out_data_q, out_data_d;

  logic                       accept;
  logic                       blank;
  logic                       is_digit;
  logic [3:0]                 digit;
  logic [ctp_pkg::ColorW-1:0] acc_scaled;
  logic [ctp_pkg::CharW-1:0]  ch;

  assign ch = s_axis_tdata_i;
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i || !s_axis_tlast_i;
  assign accept = s_axis_tvalid_i && s_axis_tready_o;
  assign blank = (ch == ctp_pkg::ChSpace) || (ch == ctp_pkg::ChTab);

  always_comb begin
    is_digit = 1'b1;
    digit    = 4'd0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      digit = 4'(ch - 8'h30);
    end else if (ch >= 8'h41 && ch <= 8'h46) begin
      digit = 4'(ch - 8'h37);
    end else if (ch >= 8'h61 && ch <= 8'h66) begin
      digit = 4'(ch - 8'h57);
    end else begin
      is_digit = 1'b0;
    end
  end

  assign acc_scaled = hex_q ? (acc_q << 4) : ((acc_q << 3) + (acc_q << 1));

  always_comb begin
    color_d     = color_q;
    acc_d       = acc_q;
    hex_d       = hex_q;
    slot_d      = slot_q;
    lead_d      = lead_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    if (accept) begin
      if (s_axis_tlast_i) begin
        if (acc_q != '0) begin
          color_d = ctp_pkg::write_channel(color_q, acc_q, slot_q);
        end
        out_data_d  = color_d;
        out_valid_d = 1'b1;
        acc_d       = '0;
        hex_d       = 1'b0;
        slot_d      = ctp_pkg::SlotRed;
        lead_d      = 1'b1;
      end else if (!(lead_q && blank)) begin
        lead_d = 1'b0;
        priority if (ch == ctp_pkg::ChHash) begin
          hex_d  = 1'b1;
          acc_d  = '0;
          slot_d = ctp_pkg::SlotWord;
        end else if (ch == ctp_pkg::ChLowX || ch == ctp_pkg::ChUpX) begin
          hex_d = 1'b1;
        end else if (blank) begin
          color_d = ctp_pkg::write_channel(color_q, acc_q, slot_q);
          if (slot_q == ctp_pkg::SlotWord) begin
            slot_d = ctp_pkg::SlotAlpha;
          end else if (slot_q < ctp_pkg::SlotNone) begin
            slot_d = slot_q + 3'd1;
          end else begin
            slot_d = ctp_pkg::SlotNone;
          end
          acc_d = '0;
          hex_d = 1'b0;
        end else if (is_digit) begin
          acc_d = acc_scaled + ctp_pkg::ColorW'(digit);
        end else begin
          acc_d = acc_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q     <= '0;
      acc_q       <= '0;
      hex_q       <= 1'b0;
      slot_q      <= ctp_pkg::SlotRed;
      lead_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      color_q     <= color_d;
      acc_q       <= acc_d;
      hex_q       <= hex_d;
      slot_q      <= slot_d;
      lead_q      <= lead_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

// ===== src/ctp_checker.sv =====
module ctp_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tvalid_i,
  input logic                       s_axis_tready_o,
  input logic                       s_axis_tlast_i,
  input logic                       m_axis_tvalid_o,
  input logic                       m_axis_tready_i,
  input logic [ctp_pkg::ColorW-1:0] m_axis_tdata_o
);

  logic s_acc;
  assign s_acc = s_axis_tvalid_i && s_axis_tready_o;

  // A stalled result word keeps its value.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled color word changed or dropped");

  // Every accepted end word yields a result in the next cycle.
  a_end_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && s_axis_tlast_i |=> m_axis_tvalid_o)
    else $error("end of string produced no color word");

  // Ordinary bytes never create a result.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && !s_axis_tlast_i && (!m_axis_tvalid_o || m_axis_tready_i) |=> !m_axis_tvalid_o)
    else $error("color word without end of string");

  // An end word is never taken over a waiting result.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i && s_acc |-> !s_axis_tlast_i)
    else $error("end of string accepted while result stalled");

endmodule

bind color_text_parser_unit ctp_checker u_ctp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tlast_i  (s_axis_tlast_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
